// ===== design/mcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpc_pkg
// Shared constants, register codes and types of the package cover unit.
// ----------------------------------------------------------------------------
package mcpc_pkg;

    // Sizing of the search.
    localparam int MAX_REQUEST      = 1024;
    localparam int MAX_PACKAGE_SIZE = 255;
    localparam int PACKAGE_SLOTS    = 4;
    localparam int TABLE_DEPTH      = MAX_REQUEST + MAX_PACKAGE_SIZE + 1;

    // Field widths.
    localparam int REQ_W   = 11;
    localparam int SIZE_W  = 8;
    localparam int PRICE_W = 20;
    localparam int COST_W  = 32;
    localparam int TOTAL_W = 31;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = $clog2(PACKAGE_SLOTS);
    localparam int TBL_AW  = $clog2(TABLE_DEPTH);

    // An unreached count holds all ones.
    localparam logic [COST_W-1:0] COST_INF = '1;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_PACKAGE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_UNREACHABLE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_PKG_A_SIZE      = 3'd0;
    localparam logic [2:0] REG_PKG_A_PRICE     = 3'd1;
    localparam logic [2:0] REG_PKG_B_SIZE      = 3'd2;
    localparam logic [2:0] REG_PKG_B_PRICE     = 3'd3;
    localparam logic [2:0] REG_PKG_C_SIZE      = 3'd4;
    localparam logic [2:0] REG_PKG_C_PRICE     = 3'd5;
    localparam logic [2:0] REG_SINGLE_PRICE    = 3'd6;
    localparam logic [2:0] REG_FLAT_UNIT_PRICE = 3'd7;

    typedef logic [PACKAGE_SLOTS-1:0][SIZE_W-1:0]  slot_size_t;
    typedef logic [PACKAGE_SLOTS-1:0][PRICE_W-1:0] slot_price_t;
    typedef logic [PACKAGE_SLOTS-1:0][REQ_W-1:0]   slot_count_t;

    // Request handed to the search engine.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [REQ_W-1:0] limit;
    } srch_cmd_t;

    // Engine status.
    typedef struct packed {
        logic busy;
        logic done;
    } srch_stat_t;

    // Engine result, stable from done until the next start.
    typedef struct packed {
        logic              unreachable;
        logic [REQ_W-1:0]  best;
        logic [COST_W-1:0] total;
        slot_count_t       counts;
    } srch_res_t;

endpackage

// ===== design/min_cost_package_cover_unit.sv =====
// ----------------------------------------------------------------------------
// min_cost_package_cover_unit
// Cheapest purchase of at least a requested item count, from three
// configured package sizes and a single-item fallback, or at a flat rate.
//
//   channel   ports        direction  carries
//   request   s_t*         in         requested count, mode flag
//   result    m_t*         out        one word per package line, tlast ends
//   config    p*           in/out     eight price and size registers
//
// Flat mode, a zero request or no enabled package: one word, staged and
// then loaded into the output register.
// Optimized mode: limit = request + largest enabled size. A table clear of
// every count up to limit, a fill that, for each count already reached,
// tries every slot and relaxes the entry of each slot that fits, a scan
// of each count from the request to limit, a traceback one package at a
// time, then one result word per line.
// The cost table memory is the bottleneck.
// Reset clears control state and the configuration registers; the tables are rebuilt for each search.
// A waiting result word holds in the output register; no new request is
// taken until the last line of the current one has been loaded there.
// ----------------------------------------------------------------------------
module min_cost_package_cover_unit
    import mcpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] requested, [15:11] zero
    input  logic [0:0]  s_tuser,   // [0] mode
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [10:0] purchased, [41:11] total_price,
                                   // [49:42] line_size, [60:50] line_quantity,
                                   // [80:61] line_unit_price, [87:81] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_ONE    = 2'd2;
    localparam logic [1:0] ST_LINES  = 2'd3;

    // Configuration registers.
    logic [SIZE_W-1:0]  pkg_a_size_reg;
    logic [PRICE_W-1:0] pkg_a_price_reg;
    logic [SIZE_W-1:0]  pkg_b_size_reg;
    logic [PRICE_W-1:0] pkg_b_price_reg;
    logic [SIZE_W-1:0]  pkg_c_size_reg;
    logic [PRICE_W-1:0] pkg_c_price_reg;
    logic [PRICE_W-1:0] single_price_reg;
    logic [PRICE_W-1:0] flat_unit_price_reg;
    logic               cfg_wr;

    logic [1:0]         state_reg, state_next;
    logic [PACKAGE_SLOTS-1:0] done_mask_reg, done_mask_next;

    // Staged single-line result.
    logic [STAT_W-1:0]  st_status_reg, st_status_next;
    logic [REQ_W-1:0]   st_purchased_reg, st_purchased_next;
    logic [TOTAL_W-1:0] st_total_reg, st_total_next;
    logic [SIZE_W-1:0]  st_size_reg, st_size_next;
    logic [REQ_W-1:0]   st_qty_reg, st_qty_next;
    logic [PRICE_W-1:0] st_unit_reg, st_unit_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [REQ_W-1:0]   out_purchased_reg, out_purchased_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic [SIZE_W-1:0]  out_size_reg, out_size_next;
    logic [REQ_W-1:0]   out_qty_reg, out_qty_next;
    logic [PRICE_W-1:0] out_unit_reg, out_unit_next;
    logic               out_last_reg, out_last_next;
    logic               out_free;

    slot_size_t         slot_size;
    slot_price_t        slot_price;
    logic [PACKAGE_SLOTS-1:0] slot_en;
    logic [SIZE_W-1:0]  largest;
    logic               any_en;

    logic               in_acc;
    logic [REQ_W-1:0]   req_in;
    logic [REQ_W-1:0]   req_sat;
    logic [TOTAL_W-1:0] flat_product;

    logic               srch_start;
    srch_cmd_t          srch_cmd;
    srch_stat_t         srch_stat;
    srch_res_t          srch_res;

    logic               pick_found;
    logic [SLOT_W-1:0]  pick_idx;
    logic               pick_more;

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkg_a_size_reg      <= '0;
            pkg_a_price_reg     <= '0;
            pkg_b_size_reg      <= '0;
            pkg_b_price_reg     <= '0;
            pkg_c_size_reg      <= '0;
            pkg_c_price_reg     <= '0;
            single_price_reg    <= '0;
            flat_unit_price_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_PKG_A_SIZE:      pkg_a_size_reg      <= pwdata[SIZE_W-1:0];
                REG_PKG_A_PRICE:     pkg_a_price_reg     <= pwdata[PRICE_W-1:0];
                REG_PKG_B_SIZE:      pkg_b_size_reg      <= pwdata[SIZE_W-1:0];
                REG_PKG_B_PRICE:     pkg_b_price_reg     <= pwdata[PRICE_W-1:0];
                REG_PKG_C_SIZE:      pkg_c_size_reg      <= pwdata[SIZE_W-1:0];
                REG_PKG_C_PRICE:     pkg_c_price_reg     <= pwdata[PRICE_W-1:0];
                REG_SINGLE_PRICE:    single_price_reg    <= pwdata[PRICE_W-1:0];
                REG_FLAT_UNIT_PRICE: flat_unit_price_reg <= pwdata[PRICE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_PKG_A_SIZE:      prdata = 32'(pkg_a_size_reg);
            REG_PKG_A_PRICE:     prdata = 32'(pkg_a_price_reg);
            REG_PKG_B_SIZE:      prdata = 32'(pkg_b_size_reg);
            REG_PKG_B_PRICE:     prdata = 32'(pkg_b_price_reg);
            REG_PKG_C_SIZE:      prdata = 32'(pkg_c_size_reg);
            REG_PKG_C_PRICE:     prdata = 32'(pkg_c_price_reg);
            REG_SINGLE_PRICE:    prdata = 32'(single_price_reg);
            REG_FLAT_UNIT_PRICE: prdata = 32'(flat_unit_price_reg);
            default:             prdata = '0;
        endcase
    end

    // Slot list: A, B, C and the single-item fallback.
    always_comb begin
        slot_size[0]  = pkg_a_size_reg;
        slot_size[1]  = pkg_b_size_reg;
        slot_size[2]  = pkg_c_size_reg;
        slot_size[3]  = SIZE_W'(1);
        slot_price[0] = pkg_a_price_reg;
        slot_price[1] = pkg_b_price_reg;
        slot_price[2] = pkg_c_price_reg;
        slot_price[3] = single_price_reg;
        largest       = '0;
        for (int s = 0; s < PACKAGE_SLOTS; s++) begin
            slot_en[s] = (slot_size[s] != '0) && (slot_price[s] != '0) &&
                         (32'(slot_size[s]) <= 32'(MAX_PACKAGE_SIZE));
            if (slot_en[s] && slot_size[s] > largest) begin
                largest = slot_size[s];
            end
        end
        any_en = |slot_en;
    end

    // Request decode.
    assign s_tready = state_reg == ST_IDLE;
    assign in_acc   = s_tvalid && s_tready;
    assign req_in   = s_tdata[REQ_W-1:0];
    assign req_sat  = (32'(req_in) > 32'(MAX_REQUEST)) ? REQ_W'(MAX_REQUEST) : req_in;
    assign flat_product = {{PRICE_W{1'b0}}, req_sat} * {{REQ_W{1'b0}}, flat_unit_price_reg};

    assign srch_start     = in_acc && !s_tuser[0] && (req_sat != '0) && any_en;
    assign srch_cmd.req   = req_sat;
    assign srch_cmd.limit = req_sat + REQ_W'(largest);

    mcpc_search u_search (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (srch_start),
        .cmd        (srch_cmd),
        .slot_size  (slot_size),
        .slot_price (slot_price),
        .slot_en    (slot_en),
        .stat       (srch_stat),
        .res        (srch_res)
    );

    // Next line: largest size among unsent slots in use, ties to higher slot.
    always_comb begin
        logic cand;
        pick_found = 1'b0;
        pick_idx   = '0;
        pick_more  = 1'b0;
        for (int s = 0; s < PACKAGE_SLOTS; s++) begin
            cand = !done_mask_reg[s] && slot_en[s] && (srch_res.counts[s] != '0);
            if (cand && (!pick_found || slot_size[s] >= slot_size[pick_idx])) begin
                pick_found = 1'b1;
                pick_idx   = SLOT_W'(s);
            end
        end
        for (int s = 0; s < PACKAGE_SLOTS; s++) begin
            cand = !done_mask_reg[s] && slot_en[s] && (srch_res.counts[s] != '0);
            if (cand && SLOT_W'(s) != pick_idx) begin
                pick_more = 1'b1;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    // Control and line emission.
    always_comb begin
        state_next         = state_reg;
        done_mask_next     = done_mask_reg;
        st_status_next     = st_status_reg;
        st_purchased_next  = st_purchased_reg;
        st_total_next      = st_total_reg;
        st_size_next       = st_size_reg;
        st_qty_next        = st_qty_reg;
        st_unit_next       = st_unit_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_status_next    = out_status_reg;
        out_purchased_next = out_purchased_reg;
        out_total_next     = out_total_reg;
        out_size_next      = out_size_reg;
        out_qty_next       = out_qty_reg;
        out_unit_next      = out_unit_reg;
        out_last_next      = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    st_status_next    = STATUS_OK;
                    st_purchased_next = '0;
                    st_total_next     = '0;
                    st_size_next      = '0;
                    st_qty_next       = '0;
                    st_unit_next      = '0;
                    done_mask_next    = '0;
                    priority if (req_sat == '0) begin
                        state_next = ST_ONE;
                    end else if (s_tuser[0]) begin
                        st_purchased_next = req_sat;
                        st_total_next     = flat_product;
                        st_size_next      = SIZE_W'(1);
                        st_qty_next       = req_sat;
                        st_unit_next      = flat_unit_price_reg;
                        state_next        = ST_ONE;
                    end else if (!any_en) begin
                        st_status_next = STATUS_NO_PACKAGE;
                        state_next     = ST_ONE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (srch_stat.done) begin
                    if (srch_res.unreachable) begin
                        st_status_next = STATUS_UNREACHABLE;
                        state_next     = ST_ONE;
                    end else begin
                        state_next = ST_LINES;
                    end
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    out_status_next    = st_status_reg;
                    out_purchased_next = st_purchased_reg;
                    out_total_next     = st_total_reg;
                    out_size_next      = st_size_reg;
                    out_qty_next       = st_qty_reg;
                    out_unit_next      = st_unit_reg;
                    out_last_next      = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            ST_LINES: begin
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    out_status_next    = STATUS_OK;
                    out_purchased_next = srch_res.best;
                    out_total_next     = srch_res.total[TOTAL_W-1:0];
                    if (pick_found) begin
                        out_size_next           = slot_size[pick_idx];
                        out_qty_next            = srch_res.counts[pick_idx];
                        out_unit_next           = slot_price[pick_idx];
                        out_last_next           = !pick_more;
                        done_mask_next[pick_idx] = 1'b1;
                        if (!pick_more) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        // Nothing traced back: one empty closing line.
                        out_size_next = '0;
                        out_qty_next  = '0;
                        out_unit_next = '0;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            done_mask_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            done_mask_reg <= done_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_status_reg     <= st_status_next;
        st_purchased_reg  <= st_purchased_next;
        st_total_reg      <= st_total_next;
        st_size_reg       <= st_size_next;
        st_qty_reg        <= st_qty_next;
        st_unit_reg       <= st_unit_next;
        out_status_reg    <= out_status_next;
        out_purchased_reg <= out_purchased_next;
        out_total_reg     <= out_total_next;
        out_size_reg      <= out_size_next;
        out_qty_reg       <= out_qty_next;
        out_unit_reg      <= out_unit_next;
        out_last_reg      <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_unit_reg, out_qty_reg, out_size_reg,
                       out_total_reg, out_purchased_reg};

`ifndef SYNTHESIS
    // The engine reports completion only while the controller waits for it.
    a_done_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        srch_stat.done |-> state_reg == ST_SEARCH)
        else $error("search done outside of search wait");

    // A new request is never taken while the engine is still working.
    a_idle_engine_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !srch_stat.busy)
        else $error("controller idle while search engine busy");

    // A started search is running in the next cycle.
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        srch_start |=> srch_stat.busy)
        else $error("search start not taken");

    // An error status is always a single closing word.
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STATUS_OK) |-> m_tlast)
        else $error("error status on a word that is not last");
`endif

endmodule

// ===== design/mcpc_search.sv =====
// ----------------------------------------------------------------------------
// mcpc_search
// Minimum-cost fill over a cost table in block memory, followed by a scan
// for the cheapest count at or above the request and a traceback that counts
// the packages used. One add-and-compare unit serves both the fill and the scan.
// ----------------------------------------------------------------------------
module mcpc_search
    import mcpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  srch_cmd_t   cmd,
    input  slot_size_t  slot_size,
    input  slot_price_t slot_price,
    input  logic [PACKAGE_SLOTS-1:0] slot_en,
    output srch_stat_t  stat,
    output srch_res_t   res
);

    localparam logic [3:0] SR_IDLE     = 4'd0;
    localparam logic [3:0] SR_CLEAR    = 4'd1;
    localparam logic [3:0] SR_LOAD     = 4'd2;
    localparam logic [3:0] SR_CUR      = 4'd3;
    localparam logic [3:0] SR_SLOT     = 4'd4;
    localparam logic [3:0] SR_UPD      = 4'd5;
    localparam logic [3:0] SR_SCAN_RD  = 4'd6;
    localparam logic [3:0] SR_SCAN_CMP = 4'd7;
    localparam logic [3:0] SR_TR_RD    = 4'd8;
    localparam logic [3:0] SR_TR_STEP  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [TBL_AW-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [COST_W-1:0] cur_reg, cur_next;
    logic [TBL_AW-1:0] nx_reg, nx_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [REQ_W-1:0]  limit_reg, limit_next;
    logic [REQ_W-1:0]  best_reg, best_next;
    logic [COST_W-1:0] best_cost_reg, best_cost_next;
    logic [TBL_AW-1:0] cursor_reg, cursor_next;
    slot_count_t       counts_reg, counts_next;

    // Cost and back-pointer tables, one write and one read port each.
    logic [COST_W-1:0] cost_mem [TABLE_DEPTH];
    logic [SLOT_W-1:0] back_mem [TABLE_DEPTH];
    logic [COST_W-1:0] cost_q;
    logic [SLOT_W-1:0] back_q;
    logic [TBL_AW-1:0] rd_addr;
    logic [TBL_AW-1:0] wr_addr;
    logic [COST_W-1:0] wr_cost;
    logic              cost_we;
    logic              back_we;

    // Shared add-and-compare unit.
    logic [COST_W:0]   unit_a;
    logic [COST_W:0]   unit_b;
    logic              unit_lt;

    logic [TBL_AW:0]   nx_sum;
    logic              last_slot;
    logic              last_cnt;
    logic [SIZE_W-1:0] back_size;
    logic              back_ok;

    always_ff @(posedge aclk) begin
        if (cost_we) begin
            cost_mem[wr_addr] <= wr_cost;
        end
        if (back_we) begin
            back_mem[wr_addr] <= slot_reg;
        end
        cost_q <= cost_mem[rd_addr];
        back_q <= back_mem[rd_addr];
    end

    // The fill adds a package price to the current cost; the scan compares
    // a table entry against the best cost seen so far.
    always_comb begin
        if (state_reg == SR_UPD) begin
            unit_a = {1'b0, cur_reg} + (COST_W+1)'(slot_price[slot_reg]);
            unit_b = {1'b0, cost_q};
        end else begin
            unit_a = {1'b0, cost_q};
            unit_b = {1'b0, best_cost_reg};
        end
        unit_lt = unit_a < unit_b;
    end

    assign nx_sum    = {1'b0, idx_reg} + (TBL_AW+1)'(slot_size[slot_reg]);
    assign last_slot = slot_reg == SLOT_W'(PACKAGE_SLOTS - 1);
    assign last_cnt  = idx_reg == TBL_AW'(limit_reg);
    assign back_size = slot_size[back_q];
    assign back_ok   = slot_en[back_q] && (TBL_AW'(back_size) <= cursor_reg);

    // Sequencer.
    always_comb begin
        logic adv;
        logic [REQ_W-1:0]  scan_best;
        logic [COST_W-1:0] scan_cost;

        state_next     = state_reg;
        done_next      = 1'b0;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        req_next       = req_reg;
        limit_next     = limit_reg;
        best_next      = best_reg;
        best_cost_next = best_cost_reg;
        cursor_next    = cursor_reg;
        counts_next    = counts_reg;
        rd_addr        = idx_reg;
        wr_addr        = idx_reg;
        wr_cost        = COST_INF;
        cost_we        = 1'b0;
        back_we        = 1'b0;
        adv            = 1'b0;
        scan_best      = best_reg;
        scan_cost      = best_cost_reg;

        unique case (state_reg)
            SR_IDLE: begin
                if (start) begin
                    req_next   = cmd.req;
                    limit_next = cmd.limit;
                    idx_next   = '0;
                    state_next = SR_CLEAR;
                end
            end
            // One entry per cycle; count zero costs nothing.
            SR_CLEAR: begin
                cost_we = 1'b1;
                wr_cost = (idx_reg == '0) ? '0 : COST_INF;
                if (last_cnt) begin
                    idx_next   = '0;
                    state_next = SR_LOAD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            SR_LOAD: begin
                state_next = SR_CUR;
            end
            // Unreached counts are skipped.
            SR_CUR: begin
                if (cost_q == COST_INF) begin
                    slot_next = SLOT_W'(PACKAGE_SLOTS - 1);
                    adv       = 1'b1;
                end else begin
                    cur_next   = cost_q;
                    slot_next  = '0;
                    state_next = SR_SLOT;
                end
            end
            SR_SLOT: begin
                if (slot_en[slot_reg] && nx_sum <= (TBL_AW+1)'(limit_reg)) begin
                    rd_addr    = nx_sum[TBL_AW-1:0];
                    nx_next    = nx_sum[TBL_AW-1:0];
                    state_next = SR_UPD;
                end else begin
                    adv = 1'b1;
                end
            end
            // Relax the target entry when the new path is strictly cheaper.
            SR_UPD: begin
                wr_addr = nx_reg;
                wr_cost = unit_a[COST_W-1:0];
                if (unit_lt) begin
                    cost_we = 1'b1;
                    back_we = 1'b1;
                end
                adv = 1'b1;
            end
            SR_SCAN_RD: begin
                state_next = SR_SCAN_CMP;
            end
            SR_SCAN_CMP: begin
                if (unit_lt) begin
                    scan_best = REQ_W'(idx_reg);
                    scan_cost = cost_q;
                end
                best_next      = scan_best;
                best_cost_next = scan_cost;
                if (last_cnt) begin
                    if (scan_cost == COST_INF) begin
                        done_next  = 1'b1;
                        state_next = SR_IDLE;
                    end else begin
                        cursor_next = TBL_AW'(scan_best);
                        counts_next = '0;
                        state_next  = SR_TR_RD;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = SR_SCAN_RD;
                end
            end
            SR_TR_RD: begin
                rd_addr = cursor_reg;
                if (cursor_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = SR_IDLE;
                end else begin
                    state_next = SR_TR_STEP;
                end
            end
            // Follow the back pointer one package down.
            SR_TR_STEP: begin
                if (back_ok) begin
                    counts_next[back_q] = counts_reg[back_q] + 1'b1;
                    cursor_next         = cursor_reg - TBL_AW'(back_size);
                    state_next          = SR_TR_RD;
                end else begin
                    done_next  = 1'b1;
                    state_next = SR_IDLE;
                end
            end
            default: begin
                state_next = SR_IDLE;
            end
        endcase

        // Next slot, or next count, or on to the scan.
        if (adv) begin
            if (!last_slot) begin
                slot_next  = slot_reg + 1'b1;
                state_next = SR_SLOT;
            end else if (last_cnt) begin
                idx_next       = TBL_AW'(req_reg);
                best_next      = req_reg;
                best_cost_next = COST_INF;
                state_next     = SR_SCAN_RD;
            end else begin
                idx_next   = idx_reg + 1'b1;
                state_next = SR_LOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SR_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        slot_reg      <= slot_next;
        cur_reg       <= cur_next;
        nx_reg        <= nx_next;
        req_reg       <= req_next;
        limit_reg     <= limit_next;
        best_reg      <= best_next;
        best_cost_reg <= best_cost_next;
        cursor_reg    <= cursor_next;
        counts_reg    <= counts_next;
    end

    assign stat.busy       = state_reg != SR_IDLE;
    assign stat.done       = done_reg;
    assign res.unreachable = best_cost_reg == COST_INF;
    assign res.best        = best_reg;
    assign res.total       = best_cost_reg;
    assign res.counts      = counts_reg;

endmodule

// ===== tb/tb_min_cost_package_cover_unit.sv =====
// ----------------------------------------------------------------------------
// tb_min_cost_package_cover_unit
// Self-checking bench for the package cover unit. Requests go in on the
// stream input while package sizes and prices are set over the register
// port between phases. A scoreboard recomputes each quote: flat rate, or a
// minimum-cost fill, count choice and traceback. It then compares every
// result word field by field. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_min_cost_package_cover_unit;
    import mcpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF   = 6;
    localparam int NO_SLOT    = 7;
    localparam int CAND_COUNT = 4;

    typedef enum logic {
        MODE_OPTIMIZED = 1'b0,
        MODE_FLAT      = 1'b1
    } buy_mode_t;

    // One result line of a quote.
    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [REQ_W-1:0]   purchased;
        logic [TOTAL_W-1:0] total;
        logic [SIZE_W-1:0]  size;
        logic [REQ_W-1:0]   qty;
        logic [PRICE_W-1:0] unit;
        logic               last;
    } quote_line_t;

    // Computes the quotes a request should produce and checks result words.
    class quote_scoreboard;
        logic [PRICE_W-1:0] reg_file[8];
        quote_line_t        quote_lines[$];
        int                 errors;

        function new();
            foreach (reg_file[i]) reg_file[i] = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [PRICE_W-1:0] value);
            if (idx == REG_PKG_A_SIZE || idx == REG_PKG_B_SIZE || idx == REG_PKG_C_SIZE)
                reg_file[idx] = {{(PRICE_W-SIZE_W){1'b0}}, value[SIZE_W-1:0]};
            else
                reg_file[idx] = value;
        endfunction

        function int pending();
            return quote_lines.size();
        endfunction

        // Appends one expected line at the tail of the pending list.
        function void queue_line(quote_line_t ln);
            quote_lines.insert(quote_lines.size(), ln);
        endfunction

        function quote_line_t make_line(logic [STAT_W-1:0] status, int unsigned purchased,
                                        logic [TOTAL_W-1:0] total, int unsigned size,
                                        int unsigned qty, logic [PRICE_W-1:0] unit);
            quote_line_t ln;
            ln.status    = status;
            ln.purchased = purchased[REQ_W-1:0];
            ln.total     = total;
            ln.size      = size[SIZE_W-1:0];
            ln.qty       = qty[REQ_W-1:0];
            ln.unit      = unit;
            ln.last      = 1'b0;
            return ln;
        endfunction

        // Works out the lines for one accepted request.
        function void note_request(buy_mode_t mode, logic [REQ_W-1:0] requested);
            int unsigned       req, lim, largest, best, cursor, c, nx;
            int                s, b, pick;
            longint unsigned   cand, flat_total;
            int unsigned       cost[TABLE_DEPTH];
            int                back[TABLE_DEPTH];
            int unsigned       use_cnt[PACKAGE_SLOTS];
            int unsigned       sz[PACKAGE_SLOTS];
            int unsigned       pr[PACKAGE_SLOTS];
            int unsigned       cand_sz[CAND_COUNT];
            int unsigned       cand_pr[CAND_COUNT];
            bit                en[PACKAGE_SLOTS];
            bit                done[PACKAGE_SLOTS];
            bit                any;
            quote_line_t       plan[$];
            quote_line_t       ln;

            req = 32'(requested);
            if (req > MAX_REQUEST)
                req = MAX_REQUEST;

            // A zero request gives one empty line in either mode.
            if (req == 0) begin
                ln = make_line(STATUS_OK, 0, '0, 0, 0, '0);
                ln.last = 1'b1;
                queue_line(ln);
                return;
            end

            // Flat rate: one line of single items.
            if (mode == MODE_FLAT) begin
                flat_total = longint'(req) * reg_file[REG_FLAT_UNIT_PRICE];
                ln = make_line(STATUS_OK, req, flat_total[TOTAL_W-1:0], 1, req,
                               reg_file[REG_FLAT_UNIT_PRICE]);
                ln.last = 1'b1;
                queue_line(ln);
                return;
            end

            cand_sz[0] = 32'(reg_file[REG_PKG_A_SIZE]);
            cand_pr[0] = 32'(reg_file[REG_PKG_A_PRICE]);
            cand_sz[1] = 32'(reg_file[REG_PKG_B_SIZE]);
            cand_pr[1] = 32'(reg_file[REG_PKG_B_PRICE]);
            cand_sz[2] = 32'(reg_file[REG_PKG_C_SIZE]);
            cand_pr[2] = 32'(reg_file[REG_PKG_C_PRICE]);
            cand_sz[3] = 1;
            cand_pr[3] = 32'(reg_file[REG_SINGLE_PRICE]);

            // A slot is usable only with a nonzero size and price in range.
            any = 1'b0;
            largest = 0;
            for (s = 0; s < PACKAGE_SLOTS; s++) begin
                sz[s] = 0; pr[s] = 0; en[s] = 1'b0; done[s] = 1'b0; use_cnt[s] = 0;
                if (s < CAND_COUNT) begin
                    sz[s] = cand_sz[s];
                    pr[s] = cand_pr[s];
                    en[s] = sz[s] != 0 && pr[s] != 0 && sz[s] <= MAX_PACKAGE_SIZE;
                end
                if (en[s]) begin
                    any = 1'b1;
                    if (sz[s] > largest)
                        largest = sz[s];
                end
            end
            if (!any) begin
                ln = make_line(STATUS_NO_PACKAGE, 0, '0, 0, 0, '0);
                ln.last = 1'b1;
                queue_line(ln);
                return;
            end

            // Minimum-cost fill over every count up to the limit.
            for (c = 0; c < TABLE_DEPTH; c++) begin
                cost[c] = COST_INF;
                back[c] = NO_SLOT;
            end
            lim = req + largest;
            cost[0] = 0;
            for (c = 0; c <= lim; c++) begin
                if (cost[c] == COST_INF)
                    continue;
                for (s = 0; s < PACKAGE_SLOTS; s++) begin
                    if (!en[s])
                        continue;
                    nx = c + sz[s];
                    if (nx > lim)
                        continue;
                    cand = longint'(cost[c]) + pr[s];
                    if (cand < cost[nx]) begin
                        cost[nx] = cand[COST_W-1:0];
                        back[nx] = s;
                    end
                end
            end

            // Cheapest count at or above the request; ties keep the lower count.
            best = req;
            for (c = req; c <= lim; c++)
                if (cost[c] < cost[best])
                    best = c;
            if (cost[best] == COST_INF) begin
                ln = make_line(STATUS_UNREACHABLE, 0, '0, 0, 0, '0);
                ln.last = 1'b1;
                queue_line(ln);
                return;
            end

            // Walk back through the chosen packages and count each kind.
            cursor = best;
            while (cursor > 0) begin
                b = back[cursor];
                if (b >= PACKAGE_SLOTS || !en[b] || sz[b] > cursor)
                    break;
                use_cnt[b] = (use_cnt[b] + 1) & 32'h7FF;
                cursor -= sz[b];
            end

            // Lines go out largest size first; equal sizes favor the higher slot.
            forever begin
                pick = -1;
                for (s = 0; s < PACKAGE_SLOTS; s++) begin
                    if (done[s] || !en[s] || use_cnt[s] == 0)
                        continue;
                    if (pick < 0 || sz[s] >= sz[pick])
                        pick = s;
                end
                if (pick < 0 || plan.size() >= CAND_COUNT)
                    break;
                done[pick] = 1'b1;
                plan.insert(plan.size(),
                            make_line(STATUS_OK, best, cost[best][TOTAL_W-1:0],
                                      sz[pick], use_cnt[pick], pr[pick][PRICE_W-1:0]));
            end
            if (plan.size() == 0)
                plan.insert(0, make_line(STATUS_OK, best, cost[best][TOTAL_W-1:0],
                                         0, 0, '0));
            plan[plan.size()-1].last = 1'b1;
            foreach (plan[i]) queue_line(plan[i]);
        endfunction

        task report_mismatch(string what, longint unsigned want, longint unsigned got);
            if (errors < 50)
                $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
            errors++;
        endtask

        // Compares one accepted result word with the oldest pending line.
        task check_line(logic [STAT_W-1:0] status, logic [87:0] data, logic last);
            quote_line_t want;
            if (quote_lines.size() == 0) begin
                report_mismatch("result word with no quote pending, status", 0, status);
                return;
            end
            want = quote_lines.pop_front();
            if (status !== want.status)
                report_mismatch("status", want.status, status);
            if (data[10:0] !== want.purchased)
                report_mismatch("purchased", want.purchased, data[10:0]);
            if (data[41:11] !== want.total)
                report_mismatch("total_price", want.total, data[41:11]);
            if (data[49:42] !== want.size)
                report_mismatch("line_size", want.size, data[49:42]);
            if (data[60:50] !== want.qty)
                report_mismatch("line_quantity", want.qty, data[60:50]);
            if (data[80:61] !== want.unit)
                report_mismatch("line_unit_price", want.unit, data[80:61]);
            if (data[87:81] !== 7'd0)
                report_mismatch("tdata padding", 0, data[87:81]);
            if (last !== want.last)
                report_mismatch("tlast", want.last, last);
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    quote_scoreboard quotes = new();

    min_cost_package_cover_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock.
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Result side: check each accepted word, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            quotes.check_line(m_tuser, m_tdata, m_tlast);
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Writes one register; psel stays high so writes can follow back to back.
    task automatic write_reg(logic [2:0] idx, logic [PRICE_W-1:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        quotes.set_reg(idx, value);
    endtask

    task automatic load_settings(logic [PRICE_W-1:0] a_size, logic [PRICE_W-1:0] a_price,
                                 logic [PRICE_W-1:0] b_size, logic [PRICE_W-1:0] b_price,
                                 logic [PRICE_W-1:0] c_size, logic [PRICE_W-1:0] c_price,
                                 logic [PRICE_W-1:0] single, logic [PRICE_W-1:0] flat);
        write_reg(REG_PKG_A_SIZE, a_size);
        write_reg(REG_PKG_A_PRICE, a_price);
        write_reg(REG_PKG_B_SIZE, b_size);
        write_reg(REG_PKG_B_PRICE, b_price);
        write_reg(REG_PKG_C_SIZE, c_size);
        write_reg(REG_PKG_C_PRICE, c_price);
        write_reg(REG_SINGLE_PRICE, single);
        write_reg(REG_FLAT_UNIT_PRICE, flat);
        psel   <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [PRICE_W-1:0] random_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r < 6)
            return PRICE_W'($urandom_range(1, 12));
        return PRICE_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [PRICE_W-1:0] random_price(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return '0;
        else if (r < 60)
            return PRICE_W'($urandom_range(1, 2000));
        return PRICE_W'($urandom_range(1, 20'hFFFFF));
    endfunction

    task automatic random_settings();
        load_settings(random_size(), random_price(10), random_size(), random_price(10),
                      random_size(), random_price(10), random_price(20), random_price(10));
    endtask

    // Offers one request word, leaving tvalid high after the handshake.
    task automatic send_request(buy_mode_t mode, logic [REQ_W-1:0] requested);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, requested};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        quotes.note_request(mode, requested);
    endtask

    // Mostly small requests keep the table fill short; a few go to the top.
    task automatic random_request();
        int        r;
        buy_mode_t mode;
        logic [REQ_W-1:0] req;
        mode = ($urandom_range(0, 3) == 0) ? MODE_FLAT : MODE_OPTIMIZED;
        r = $urandom_range(0, 99);
        if (r < 5)
            req = '0;
        else if (r < 70)
            req = REQ_W'($urandom_range(1, 40));
        else if (r < 90)
            req = REQ_W'($urandom_range(41, 300));
        else
            req = REQ_W'($urandom_range(301, 2047));
        send_request(mode, req);
    endtask

    // Waits until every quote has come back and the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (quotes.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Main sequence.
    initial begin
        int phase, half;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_gap_pct   = 38;
        recv_stall_pct = 75;

        // Registers at reset: nothing enabled, flat price zero.
        send_request(MODE_OPTIMIZED, 11'd5);
        send_request(MODE_FLAT, 11'd7);
        send_request(MODE_OPTIMIZED, 11'd0);
        send_request(MODE_FLAT, 11'd0);
        drain();

        // Two slots of equal size, maximum flat price, saturated requests.
        load_settings(20'd10, 20'd800, 20'd4, 20'd350, 20'd4, 20'd340, 20'd100, 20'hFFFFF);
        send_request(MODE_OPTIMIZED, 11'd1);
        send_request(MODE_OPTIMIZED, 11'd3);
        send_request(MODE_OPTIMIZED, 11'd9);
        send_request(MODE_OPTIMIZED, 11'd17);
        send_request(MODE_OPTIMIZED, 11'd23);
        send_request(MODE_FLAT, 11'd2047);
        send_request(MODE_FLAT, 11'd1024);
        send_request(MODE_OPTIMIZED, 11'd1024);
        drain();

        // Only the largest package at the top price; other slots half disabled.
        load_settings(20'd255, 20'hFFFFF, 20'd0, 20'd5, 20'd1, 20'd0, 20'd0, 20'd1);
        send_request(MODE_OPTIMIZED, 11'd1);
        send_request(MODE_OPTIMIZED, 11'd2047);
        send_request(MODE_OPTIMIZED, 11'd256);
        send_request(MODE_FLAT, 11'd1);
        drain();

        // A cheap big package next to a small one and a costly single item.
        load_settings(20'd3, 20'd250, 20'd0, 20'd0, 20'd200, 20'd1, 20'hFFFFF, 20'd0);
        send_request(MODE_OPTIMIZED, 11'd2);
        send_request(MODE_OPTIMIZED, 11'd199);
        send_request(MODE_OPTIMIZED, 11'd600);
        drain();

        // Random phases: receiver stalls, then sender gaps, then full rate.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct   = 38;
                    recv_stall_pct = 75;
                end
                1: begin
                    send_gap_pct   = 75;
                    recv_stall_pct = 38;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (half = 0; half < 2; half++) begin
                random_settings();
                repeat (14) random_request();
                drain();
            end
        end

        repeat (20) @(posedge aclk);
        if (quotes.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit, well above the slowest legal run.
    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== min_cost_package_cover_unit.f =====
design/mcpc_pkg.sv
design/mcpc_search.sv
design/min_cost_package_cover_unit.sv
tb/tb_min_cost_package_cover_unit.sv
